@@ design/biu_pkg.sv @@
// Shared types, constants and color helpers for the bilinear upscaler.
package biu_pkg;

  localparam int MaxSrcWidth  = 64;
  localparam int MaxSrcHeight = 64;
  localparam int MaxRun       = 64;
  localparam int ColW         = $clog2(MaxSrcWidth);
  localparam int RowW         = $clog2(MaxSrcHeight);
  localparam int AddrW        = ColW + RowW;

  typedef enum logic [2:0] {
    CfgSrcWidth   = 3'd0,
    CfgSrcHeight  = 3'd1,
    CfgDstWidth   = 3'd2,
    CfgDstHeight  = 3'd3,
    CfgXScale     = 3'd4,
    CfgYScale     = 3'd5,
    CfgTransColor = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StRowMul,
    StColMul,
    StRd11,
    StRd12,
    StRd21,
    StRd22,
    StMixH,
    StMixV,
    StOut,
    StErr
  } state_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic rgb_t unpack565(input logic [15:0] p);
    rgb_t c;
    c.r = {p[15:11], 3'b000};
    c.g = {p[10:5], 2'b00};
    c.b = {p[4:0], 3'b000};
    return c;
  endfunction

  function automatic logic [15:0] pack565(input rgb_t c);
    return {c.r[7:3], c.g[7:2], c.b[7:3]};
  endfunction

endpackage

@@ design/bilinear_image_upscaler.sv @@
// Bilinear RGB565 upscaler top level: source store, sequencer and output register.
// A pixel write beat is written to the source memory when it is taken. A run
// request of N pixels runs a small sequencer: a setup state for the row
// coordinate multiply, then for each pixel one column multiply, four reads of
// the source memory, and three passes through the shared blend unit (upper
// row, lower row, then vertical in the output state). The four memory reads
// and the three blend passes set the length of each pixel's sequence. Each
// beat of a run is loaded into the output register from the output state,
// and a stalled output holds the sequencer in its output state. A rejected
// run passes through the error state and gives one error beat. The block
// takes no new request until the last beat of a run has been loaded
// into the output register.
module bilinear_image_upscaler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [22:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [5:0]  src_x_i,
  input  logic [5:0]  src_y_i,
  input  logic [15:0] src_pixel_i,
  input  logic [11:0] dst_x_i,
  input  logic [11:0] dst_y_i,
  input  logic [6:0]  run_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_out_o,
  output logic        last_o,
  output logic        error_o
);
  import biu_pkg::*;

  // configuration registers
  logic [6:0]  src_w_q, src_h_q;
  logic [11:0] dst_w_q, dst_h_q;
  logic [22:0] xs_q, ys_q;
  logic [15:0] trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 7'd64; src_h_q <= 7'd64;
      dst_w_q <= 12'd64; dst_h_q <= 12'd64;
      xs_q <= 23'd65536; ys_q <= 23'd65536;
      trans_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSrcWidth:   src_w_q <= cfg_data_i[6:0];
        CfgSrcHeight:  src_h_q <= cfg_data_i[6:0];
        CfgDstWidth:   dst_w_q <= cfg_data_i[11:0];
        CfgDstHeight:  dst_h_q <= cfg_data_i[11:0];
        CfgXScale:     xs_q <= cfg_data_i;
        CfgYScale:     ys_q <= cfg_data_i;
        CfgTransColor: trans_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // clamped last column / row
  logic [ColW-1:0] wmax;
  logic [RowW-1:0] hmax;
  always_comb begin
    if (src_w_q == 7'd0) wmax = '0;
    else if (src_w_q > 7'(MaxSrcWidth)) wmax = ColW'(MaxSrcWidth - 1);
    else wmax = ColW'(src_w_q - 7'd1);
    if (src_h_q == 7'd0) hmax = '0;
    else if (src_h_q > 7'(MaxSrcHeight)) hmax = RowW'(MaxSrcHeight - 1);
    else hmax = RowW'(src_h_q - 7'd1);
  end

  state_e state_q, state_d;
  logic [11:0] x_q;
  logic [11:0] y_q;
  logic [6:0]  left_q;
  logic [34:0] prod_q;   // shared multiplier result
  logic [RowW-1:0] r1_q, r2_q;
  logic [15:0] fy_q;
  logic [ColW-1:0] c1_q, c2_q;
  logic [15:0] fx_q;
  logic [15:0] p11_q, p12_q, p21_q, p22_q;
  rgb_t h1_q, h2_q;
  logic [15:0] pix_q;
  logic last_q, err_q, ov_q;

  logic in_acc, out_acc, run_bad;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = ov_q && !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign run_bad = (run_length_i == 7'd0) || (run_length_i > 7'(MaxRun)) ||
                   (dst_x_i >= dst_w_q) ||
                   ({1'b0, dst_x_i} + {6'd0, run_length_i} > {1'b0, dst_w_q}) ||
                   (dst_y_i >= dst_h_q);

  // clamped source column / row from the multiplier result
  logic [RowW-1:0] r1n;
  logic [ColW-1:0] c1n;
  always_comb begin
    r1n = (prod_q[34:16] > {{(19-RowW){1'b0}}, hmax}) ? hmax : prod_q[16+RowW-1:16];
    c1n = (prod_q[34:16] > {{(19-ColW){1'b0}}, wmax}) ? wmax : prod_q[16+ColW-1:16];
  end

  // source memory, one write and one read port; the first column comes straight from the product
  logic [15:0] mem [MaxSrcWidth*MaxSrcHeight];
  logic [AddrW-1:0] raddr;
  logic [15:0] rdata_q;
  always_comb begin
    unique case (state_q)
      StRd11:  raddr = {r1_q, c1n};
      StRd12:  raddr = {r1_q, c2_q};
      StRd21:  raddr = {r2_q, c1_q};
      default: raddr = {r2_q, c2_q};
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (in_acc && !req_type_i) mem[{src_y_i, src_x_i}] <= src_pixel_i;
    rdata_q <= mem[raddr];
  end

  // shared multiplier: 12 x 23; the row product is redone in the output
  // cycle so that it is back in prod_q for the next pixel
  logic        row_sel;
  logic [11:0] mul_a;
  logic [22:0] mul_b;
  logic [34:0] mul_res;
  assign row_sel = (state_q == StRowMul) || (state_q == StOut);
  assign mul_a   = row_sel ? y_q : x_q;
  assign mul_b   = row_sel ? ys_q : xs_q;
  assign mul_res = {23'd0, mul_a} * {12'd0, mul_b};

  // shared blend unit: upper row, lower row, then the vertical pass
  rgb_t mix_a, mix_b, mix_o;
  logic [15:0] mix_f;
  logic mix_hold;
  always_comb begin
    unique case (state_q)
      StMixH: begin
        mix_a = unpack565(p11_q); mix_b = unpack565(p12_q); mix_f = fx_q;
        mix_hold = (p11_q == trans_q) || (p12_q == trans_q);
      end
      StMixV: begin
        mix_a = unpack565(p21_q); mix_b = unpack565(p22_q); mix_f = fx_q;
        mix_hold = (p21_q == trans_q) || (p22_q == trans_q);
      end
      default: begin
        mix_a = h1_q; mix_b = h2_q; mix_f = fy_q;
        mix_hold = (pack565(h1_q) == trans_q) || (pack565(h2_q) == trans_q);
      end
    endcase
  end
  biu_mixer u_mix (.a_i(mix_a), .b_i(mix_b), .f_i(mix_f), .hold_i(mix_hold), .o_o(mix_o));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_acc && req_type_i) state_d = run_bad ? StErr : StRowMul;
      StRowMul: state_d = StColMul;
      StColMul: state_d = StRd11;
      StRd11:   state_d = StRd12;
      StRd12:   state_d = StRd21;
      StRd21:   state_d = StRd22;
      StRd22:   state_d = StMixH;
      StMixH:   state_d = StMixV;
      StMixV:   state_d = StOut;
      StOut:    if (!ov_q || out_acc) state_d = (left_q == 7'd1) ? StIdle : StColMul;
      StErr:    if (!ov_q || out_acc) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_res;
    unique case (state_q)
      StIdle: if (in_acc) begin
        x_q <= dst_x_i; y_q <= dst_y_i; left_q <= run_length_i;
      end
      StColMul: begin
        r1_q <= r1n;
        r2_q <= (r1n == hmax) ? hmax : r1n + RowW'(1);
        fy_q <= prod_q[15:0];
      end
      StRd11: begin
        c1_q <= c1n;
        c2_q <= (c1n == wmax) ? wmax : c1n + ColW'(1);
        fx_q <= prod_q[15:0];
      end
      StRd12: p11_q <= rdata_q;
      StRd21: p12_q <= rdata_q;
      StRd22: p21_q <= rdata_q;
      StMixH: begin p22_q <= rdata_q; h1_q <= mix_o; end
      StMixV: begin h2_q <= mix_o; end
      StOut: if (!ov_q || out_acc) begin
        x_q <= x_q + 12'd1; left_q <= left_q - 7'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (((state_q == StOut) || (state_q == StErr)) && (!ov_q || out_acc)) begin
      ov_q <= 1'b1;
    end else if (out_acc) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StErr && (!ov_q || out_acc)) begin
      pix_q <= '0; last_q <= 1'b1; err_q <= 1'b1;
    end else if (state_q == StOut && (!ov_q || out_acc)) begin
      pix_q <= pack565(mix_o); last_q <= (left_q == 7'd1); err_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign pixel_out_o = pix_q;
  assign last_o = last_q;
  assign error_o = err_q;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o) &&
                                   $stable(last_o) && $stable(error_o));
  // an error beat is a single zero beat
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o && (pixel_out_o == 16'd0));
  // a taken run request makes the block busy
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i |=> in_stall_o);

endmodule

@@ design/biu_mixer.sv @@
// Shared channel blend unit: one RGB pair with one 16-bit fraction per use; on hold it picks the nearer input.
module biu_mixer (
  input  biu_pkg::rgb_t        a_i,
  input  biu_pkg::rgb_t        b_i,
  input  logic          [15:0] f_i,
  input  logic                 hold_i,
  output biu_pkg::rgb_t        o_o
);
  import biu_pkg::*;

  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                     input logic [15:0] f);
    logic [16:0] nf;
    logic [25:0] v;
    nf = 17'h10000 - {1'b0, f};
    v  = ({18'd0, a} * {9'd0, nf}) + ({18'd0, b} * {10'd0, f});
    return (v[25:16] > 10'd255) ? 8'hFF : v[23:16];
  endfunction

  always_comb begin
    if (hold_i) begin
      o_o = f_i[15] ? b_i : a_i;
    end else begin
      o_o.r = mix(a_i.r, b_i.r, f_i);
      o_o.g = mix(a_i.g, b_i.g, f_i);
      o_o.b = mix(a_i.b, b_i.b, f_i);
    end
  end

endmodule
